// ----- rtl/mfld_pkg.sv -----
// shared types and constants for the mono framebuffer line draw block
// no dependencies
package mfld_pkg;

   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_READ  = 3'd1,
      OP_AXIS  = 3'd2,
      OP_DDA   = 3'd3,
      OP_FILL  = 3'd4
   } op_type;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [7:0] WIDTH_RESET  = 8'd128;
   localparam logic [6:0] HEIGHT_RESET = 7'd64;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] x_start;
      logic [7:0] y_start;
      logic [7:0] x_end;
      logic [7:0] y_end;
      logic       pixel_value;
      logic [7:0] fill_byte;
   } req_type;

   typedef struct packed {
      logic pixel_out;
      logic status;
   } rsp_type;

   // one pixel access or fill command handed to the frame store
   typedef struct packed {
      logic       go;
      logic       fill;
      logic       read;
      logic [7:0] x;
      logic [7:0] y;
      logic       value;
      logic [7:0] fill_byte;
   } pix_cmd_type;

   typedef struct packed {
      logic done;
      logic dropped;
      logic pixel;
   } pix_ack_type;

endpackage

// ----- rtl/mfld_if.sv -----
// valid/ready channel carrying one payload of a generic type
// depends on mfld_pkg for the payload types at instantiation
interface mfld_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/mfld_store.sv -----
// frame store with pixel read-modify-write, pixel read and fill sweep
// depends on mfld_pkg
module mfld_store #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            act_w,
   input  logic [8:0]            act_h,
   input  mfld_pkg::pix_cmd_type cmd,
   output mfld_pkg::pix_ack_type ack,
   output logic                  idle
);
   import mfld_pkg::*;

   localparam int ROW_BYTES = (MAX_WIDTH + 7) / 8;
   localparam int DEPTH     = ROW_BYTES * MAX_HEIGHT;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW        = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_ADDR, S_READ, S_WRITE, S_FILL} state_type;

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_ff;
   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic [16:0]   idx_ff, idx_in;
   logic [2:0]    bit_ff, bit_in;
   logic          val_ff, val_in;
   logic          rdo_ff, rdo_in;
   logic [7:0]    fb_ff, fb_in;
   pix_ack_type   ack_ff, ack_in;
   logic          we;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;
   logic [5:0]    row_bytes;
   logic [7:0]    merged;

   assign row_bytes = 6'((9'(act_w) + 9'd7) >> 3);
   assign ack = ack_ff;
   assign idle = (state_ff == S_IDLE);

   // merge the pixel bit into the byte read
   always_comb begin
      merged = rd_ff;
      merged[3'd7 - bit_ff] = val_ff;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      lim_in   = lim_ff;
      idx_in   = idx_ff;
      bit_in   = bit_ff;
      val_in   = val_ff;
      rdo_in   = rdo_ff;
      fb_in    = fb_ff;
      ack_in   = '0;
      we       = 1'b0;
      waddr    = cnt_ff[AW-1:0];
      wdata    = '0;
      unique case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.go) begin
               if (cmd.fill) begin
                  cnt_in = '0;
                  lim_in = (18'(row_bytes) * 18'(act_h) > 18'(DEPTH)) ? CW'(DEPTH)
                           : CW'(18'(row_bytes) * 18'(act_h));
                  fb_in = cmd.fill_byte;
                  state_in = S_FILL;
               end else if (9'(cmd.x) >= 9'(act_w) || 9'(cmd.y) >= act_h) begin
                  ack_in = '{done: 1'b1, dropped: 1'b1, pixel: 1'b0};
               end else begin
                  idx_in = 17'(cmd.y) * 17'(row_bytes) + 17'(cmd.x[7:3]);
                  bit_in = cmd.x[2:0];
                  val_in = cmd.value;
                  rdo_in = cmd.read;
                  state_in = S_ADDR;
               end
            end
         end
         S_ADDR: begin
            if (idx_ff >= 17'(DEPTH)) begin
               ack_in = '{done: 1'b1, dropped: 1'b1, pixel: 1'b0};
               state_in = S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_WRITE;
         S_WRITE: begin
            // a pixel read leaves the byte untouched
            we = !rdo_ff;
            waddr = idx_ff[AW-1:0];
            wdata = merged;
            ack_in = '{done: 1'b1, dropped: 1'b0, pixel: rd_ff[3'd7 - bit_ff]};
            state_in = S_IDLE;
         end
         S_FILL: begin
            if (cnt_ff >= lim_ff) begin
               ack_in = '{done: 1'b1, dropped: 1'b0, pixel: 1'b0};
               state_in = S_IDLE;
            end else begin
               we = 1'b1;
               wdata = fb_ff;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory port: one write, one registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         ack_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ack_ff   <= ack_in;
      end
      lim_ff <= lim_in;
      idx_ff <= idx_in;
      bit_ff <= bit_in;
      val_ff <= val_in;
      rdo_ff <= rdo_in;
      fb_ff  <= fb_in;
   end
endmodule

// ----- rtl/mono_framebuffer_line_draw.sv -----
// top level: command sequencer and line walker over the frame store
// depends on mfld_pkg, mfld_if and mfld_store
//
// Each transaction is one command and gives one response. A command runs
// alone: req ready is low from acceptance until the response is taken.
// Each pixel access goes to the single store port, which steps through
// address check, read and write before it acknowledges; a DDA point first
// runs the bit-serial divider (both offsets divided by the step count
// together, a load step and 16 quotient steps), then forms the point.
// A fill writes one byte a cycle. After reset all ((MAX_WIDTH+7)/8)*MAX_HEIGHT
// bytes of the store are cleared, one byte a cycle; req ready stays low
// until the clear has finished.
module mono_framebuffer_line_draw #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data,
   mfld_if.sink       req,
   mfld_if.source     rsp
);
   import mfld_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_PIX, S_PIX_WAIT, S_AXIS_NEXT, S_DDA_DIV,
      S_DDA_NEXT, S_FILL_WAIT, S_RESP
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  wreg_ff, wreg_in;
   logic [6:0]  hreg_ff, hreg_in;
   logic [7:0]  act_w;
   logic [8:0]  act_h;
   req_type     cmd_ff, cmd_in;
   logic        st_ff, st_in;
   logic        pix_ff, pix_in;
   logic        rv_ff, rv_in;
   // walker
   logic [1:0]  edge_ff, edge_in;
   logic [1:0]  nedge_ff, nedge_in;
   logic        vert_ff, vert_in;
   logic [7:0]  fix_ff, fix_in;
   logic [7:0]  t_ff, t_in;
   logic [7:0]  tend_ff, tend_in;
   logic [7:0]  px_ff, px_in;
   logic [7:0]  py_ff, py_in;
   // dda
   logic [7:0]  adx_ff, adx_in, ady_ff, ady_in, steps_ff, steps_in, i_ff, i_in;
   logic        sx_ff, sx_in, sy_ff, sy_in;
   logic [15:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [8:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic [8:0]  rx_sh, ry_sh;
   pix_cmd_type scmd;
   pix_ack_type sack;
   logic        store_idle;

   assign act_w = (9'(wreg_ff) > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : wreg_ff;
   assign act_h = (9'(hreg_ff) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(hreg_ff);

   assign req.ready   = (state_ff == S_IDLE) && !rv_ff && store_idle;
   assign rsp.valid   = rv_ff;
   assign rsp.payload = '{pixel_out: pix_ff, status: st_ff};

   mfld_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_store (
      .clock (clock),
      .reset (reset),
      .act_w (act_w),
      .act_h (act_h),
      .cmd   (scmd),
      .ack   (sack),
      .idle  (store_idle)
   );

   // restoring divider steps, one for x and one for y
   assign rx_sh = {rx_ff[7:0], nx_ff[15]};
   assign ry_sh = {ry_ff[7:0], ny_ff[15]};

   always_comb begin
      state_in = state_ff;
      wreg_in = wreg_ff; hreg_in = hreg_ff;
      cmd_in = cmd_ff; st_in = st_ff; pix_in = pix_ff; rv_in = rv_ff;
      edge_in = edge_ff; nedge_in = nedge_ff; vert_in = vert_ff; fix_in = fix_ff;
      t_in = t_ff; tend_in = tend_ff; px_in = px_ff; py_in = py_ff;
      adx_in = adx_ff; ady_in = ady_ff; steps_in = steps_ff; i_in = i_ff;
      sx_in = sx_ff; sy_in = sy_ff; nx_in = nx_ff; ny_in = ny_ff;
      rx_in = rx_ff; ry_in = ry_ff; dcnt_in = dcnt_ff;
      scmd = '{go: 1'b0, fill: 1'b0, read: (cmd_ff.op == OP_READ), x: px_ff, y: py_ff,
               value: cmd_ff.pixel_value, fill_byte: cmd_ff.fill_byte};

      // configuration writes
      if (csr_write_enable) begin
         if (csr_index == CSR_WIDTH) wreg_in = csr_write_data;
         else                        hreg_in = csr_write_data[6:0];
      end
      if (rv_ff && rsp.ready) rv_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.payload;
               st_in = 1'b0; pix_in = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            px_in = cmd_ff.x_start; py_in = cmd_ff.y_start;
            if (cmd_ff.op == OP_WRITE || cmd_ff.op == OP_READ) begin
               state_in = S_PIX;
            end else if (cmd_ff.op == OP_FILL) begin
               scmd.go = 1'b1; scmd.fill = 1'b1;
               state_in = S_FILL_WAIT;
            end else if (cmd_ff.op == OP_AXIS) begin
               if (9'(cmd_ff.x_start) >= 9'(act_w) || 9'(cmd_ff.x_end) >= 9'(act_w)
                   || 9'(cmd_ff.y_start) >= act_h || 9'(cmd_ff.y_end) >= act_h) begin
                  st_in = 1'b1; state_in = S_RESP;
               end else begin
                  // edges: 0 row y_start, 1 col x_start, 2 col x_end, 3 row y_end
                  vert_in = (cmd_ff.x_start == cmd_ff.x_end);
                  edge_in = 2'd0;
                  nedge_in = (cmd_ff.x_start == cmd_ff.x_end
                              || cmd_ff.y_start == cmd_ff.y_end) ? 2'd0 : 2'd3;
                  if (cmd_ff.x_start == cmd_ff.x_end) begin
                     fix_in = cmd_ff.x_start;
                     t_in = (cmd_ff.y_start < cmd_ff.y_end) ? cmd_ff.y_start : cmd_ff.y_end;
                     tend_in = (cmd_ff.y_start < cmd_ff.y_end) ? cmd_ff.y_end : cmd_ff.y_start;
                  end else begin
                     fix_in = cmd_ff.y_start;
                     t_in = (cmd_ff.x_start < cmd_ff.x_end) ? cmd_ff.x_start : cmd_ff.x_end;
                     tend_in = (cmd_ff.x_start < cmd_ff.x_end) ? cmd_ff.x_end : cmd_ff.x_start;
                  end
                  state_in = S_AXIS_NEXT;
               end
            end else if (cmd_ff.op == OP_DDA) begin
               sx_in = cmd_ff.x_end >= cmd_ff.x_start;
               sy_in = cmd_ff.y_end >= cmd_ff.y_start;
               adx_in = sx_in ? cmd_ff.x_end - cmd_ff.x_start : cmd_ff.x_start - cmd_ff.x_end;
               ady_in = sy_in ? cmd_ff.y_end - cmd_ff.y_start : cmd_ff.y_start - cmd_ff.y_end;
               steps_in = (adx_in > ady_in) ? adx_in : ady_in;
               i_in = 8'd0;
               if (steps_in == 8'd0) begin
                  state_in = S_PIX;
               end else begin
                  nx_in = '0; ny_in = '0; rx_in = '0; ry_in = '0; dcnt_in = '0;
                  state_in = S_DDA_DIV;
               end
            end else begin
               st_in = 1'b1; state_in = S_RESP;
            end
         end
         S_AXIS_NEXT: begin
            px_in = vert_ff ? fix_ff : t_ff;
            py_in = vert_ff ? t_ff : fix_ff;
            state_in = S_PIX;
         end
         S_DDA_DIV: begin
            // one quotient bit per cycle for both offsets, 16 steps
            if (dcnt_ff == 5'd0) begin
               nx_in = 16'(i_ff) * 16'(adx_ff);
               ny_in = 16'(i_ff) * 16'(ady_ff);
               rx_in = '0; ry_in = '0;
               dcnt_in = 5'd1;
            end else begin
               nx_in = {nx_ff[14:0], 1'b0}; ny_in = {ny_ff[14:0], 1'b0};
               rx_in = rx_sh; ry_in = ry_sh;
               if (rx_sh >= 9'(steps_ff)) begin
                  rx_in = rx_sh - 9'(steps_ff); nx_in[0] = 1'b1;
               end
               if (ry_sh >= 9'(steps_ff)) begin
                  ry_in = ry_sh - 9'(steps_ff); ny_in[0] = 1'b1;
               end
               dcnt_in = dcnt_ff + 1'b1;
               if (dcnt_ff == 5'd16) begin
                  dcnt_in = 5'd0;
                  state_in = S_DDA_NEXT;
               end
            end
         end
         S_DDA_NEXT: begin
            // quotients are below 256 since i <= steps
            px_in = sx_ff ? cmd_ff.x_start + nx_ff[7:0] : cmd_ff.x_start - nx_ff[7:0];
            py_in = sy_ff ? cmd_ff.y_start + ny_ff[7:0] : cmd_ff.y_start - ny_ff[7:0];
            state_in = S_PIX;
         end
         S_PIX: begin
            scmd.go = 1'b1;
            state_in = S_PIX_WAIT;
         end
         S_PIX_WAIT: begin
            if (sack.done) begin
               if (cmd_ff.op == OP_READ) begin
                  st_in = sack.dropped;
                  pix_in = sack.pixel;
                  state_in = S_RESP;
               end else if (cmd_ff.op == OP_AXIS) begin
                  if (t_ff != tend_ff) begin
                     t_in = t_ff + 1'b1;
                     state_in = S_AXIS_NEXT;
                  end else if (edge_ff != nedge_ff) begin
                     edge_in = edge_ff + 1'b1;
                     state_in = S_AXIS_NEXT;
                     unique case (edge_in)
                        2'd1: begin
                           vert_in = 1'b1; fix_in = cmd_ff.x_start;
                           t_in = (cmd_ff.y_start < cmd_ff.y_end) ? cmd_ff.y_start
                                                                  : cmd_ff.y_end;
                           tend_in = (cmd_ff.y_start < cmd_ff.y_end) ? cmd_ff.y_end
                                                                     : cmd_ff.y_start;
                        end
                        2'd2: begin
                           vert_in = 1'b1; fix_in = cmd_ff.x_end;
                           t_in = (cmd_ff.y_start < cmd_ff.y_end) ? cmd_ff.y_start
                                                                  : cmd_ff.y_end;
                           tend_in = (cmd_ff.y_start < cmd_ff.y_end) ? cmd_ff.y_end
                                                                     : cmd_ff.y_start;
                        end
                        default: begin
                           vert_in = 1'b0; fix_in = cmd_ff.y_end;
                           t_in = (cmd_ff.x_start < cmd_ff.x_end) ? cmd_ff.x_start
                                                                  : cmd_ff.x_end;
                           tend_in = (cmd_ff.x_start < cmd_ff.x_end) ? cmd_ff.x_end
                                                                     : cmd_ff.x_start;
                        end
                     endcase
                  end else begin
                     state_in = S_RESP;
                  end
               end else if (cmd_ff.op == OP_DDA) begin
                  st_in = st_ff | sack.dropped;
                  if (i_ff == steps_ff) begin
                     state_in = S_RESP;
                  end else begin
                     i_in = i_ff + 1'b1;
                     state_in = S_DDA_DIV;
                  end
               end else begin
                  st_in = sack.dropped;
                  state_in = S_RESP;
               end
            end
         end
         S_FILL_WAIT: begin
            if (sack.done) state_in = S_RESP;
         end
         S_RESP: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         wreg_ff  <= WIDTH_RESET;
         hreg_ff  <= HEIGHT_RESET;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         wreg_ff  <= wreg_in;
         hreg_ff  <= hreg_in;
         dcnt_ff  <= dcnt_in;
      end
      cmd_ff <= cmd_in; st_ff <= st_in; pix_ff <= pix_in;
      edge_ff <= edge_in; nedge_ff <= nedge_in; vert_ff <= vert_in; fix_ff <= fix_in;
      t_ff <= t_in; tend_ff <= tend_in; px_ff <= px_in; py_ff <= py_in;
      adx_ff <= adx_in; ady_ff <= ady_in; steps_ff <= steps_in; i_ff <= i_in;
      sx_ff <= sx_in; sy_ff <= sy_in; nx_ff <= nx_in; ny_ff <= ny_in;
      rx_ff <= rx_in; ry_ff <= ry_in;
   end
endmodule
